// ===== rtl/utf8d_pkg.sv =====
package utf8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEFT_W  = 3;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned PEND_W  = 2;
    localparam int unsigned LEN_W   = 3;

    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
    localparam logic [BYTE_W-1:0] PAYLOAD6    = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS  = 8'h07;

    localparam logic [LEFT_W-1:0] LEFT_LAST   = 3'd1;
    localparam logic [LEFT_W-1:0] LEFT_MAX    = 3'd4;

    localparam logic [LEN_W-1:0]  LEN_BAD     = 3'd0;
    localparam logic [LEN_W-1:0]  LEN_ONE     = 3'd1;
    localparam logic [LEN_W-1:0]  LEN_TWO     = 3'd2;
    localparam logic [LEN_W-1:0]  LEN_THREE   = 3'd3;
    localparam logic [LEN_W-1:0]  LEN_FOUR    = 3'd4;

    typedef struct packed {
        logic [PEND_W-1:0] pending;
        logic [CP_W-1:0]   partial;
        logic              dropping;
    } dec_state_t;

endpackage

// ===== rtl/utf8d_step.sv =====
module utf8d_step
    import utf8d_pkg::*;
(
    input  dec_state_t        state_cur,
    input  logic [BYTE_W-1:0] byte_in,
    input  logic [LEFT_W-1:0] bytes_left,
    output dec_state_t        state_next,
    output logic              emit,
    output logic [CP_W-1:0]   cp_out
);

    logic [LEFT_W-1:0] left_sat;
    logic              last;
    logic [LEN_W-1:0]  lead_len;
    logic [CP_W-1:0]   lead_bits;
    logic [CP_W-1:0]   shifted;
    logic [PEND_W-1:0] pend_dec;
    logic              is_cont;
    logic              reprocess;

    // saturate remaining count into 1..4
    always_comb begin
        if (bytes_left == '0) begin
            left_sat = LEFT_LAST;
        end else if (bytes_left > LEFT_MAX) begin
            left_sat = LEFT_MAX;
        end else begin
            left_sat = bytes_left;
        end
    end

    assign last     = (left_sat == LEFT_LAST);
    assign is_cont  = ((byte_in & CONT_MASK) == CONT_TAG);
    assign shifted  = {state_cur.partial[CP_W-7:0], (byte_in[5:0] & PAYLOAD6[5:0])};
    assign pend_dec = state_cur.pending - PEND_W'(1);

    // lead byte classification
    always_comb begin
        case (byte_in) inside
            8'b0???????: begin
                lead_len  = LEN_ONE;
                lead_bits = CP_W'(byte_in);
            end
            8'b110?????: begin
                lead_len  = LEN_TWO;
                lead_bits = CP_W'(byte_in & LEAD2_BITS);
            end
            8'b1110????: begin
                lead_len  = LEN_THREE;
                lead_bits = CP_W'(byte_in & LEAD3_BITS);
            end
            8'b11110???: begin
                lead_len  = LEN_FOUR;
                lead_bits = CP_W'(byte_in & LEAD4_BITS);
            end
            default: begin
                lead_len  = LEN_BAD;
                lead_bits = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_cur;
        emit       = 1'b0;
        cp_out     = '0;
        reprocess  = 1'b0;
        if (state_cur.dropping) begin
            if (last) begin
                state_next.dropping = 1'b0;
            end
        end else begin
            reprocess = 1'b1;
            if (state_cur.pending != '0) begin
                if (is_cont) begin
                    reprocess          = 1'b0;
                    state_next.partial = shifted;
                    state_next.pending = pend_dec;
                    if (pend_dec == '0) begin
                        emit   = 1'b1;
                        cp_out = shifted;
                    end else if (last) begin
                        state_next.pending = '0;
                        state_next.partial = '0;
                    end
                end else begin
                    // bad continuation, retry as lead
                    state_next.pending = '0;
                    state_next.partial = '0;
                end
            end
            if (reprocess) begin
                if (lead_len == LEN_BAD) begin
                    emit = 1'b0;
                end else if (lead_len > left_sat) begin
                    state_next.dropping = !last;
                end else if (lead_len == LEN_ONE) begin
                    emit   = 1'b1;
                    cp_out = lead_bits;
                end else begin
                    state_next.pending = PEND_W'(lead_len - LEN_ONE);
                    state_next.partial = lead_bits;
                end
            end
        end
    end

endmodule

// ===== rtl/utf8_to_code_point_decoder.sv =====
// channel   | ports                                  | direction
// ----------+----------------------------------------+----------
// input     | s_valid s_ready s_byte_in s_bytes_left | in
// result    | m_valid m_ready m_cp                   | out
//
// one byte per cycle unless m_ready stalls; the code point of a last byte passes
// through the input register, then the result register
// aresetn clears the decode state and both valid flags
// a stall on m_ready holds the result and the input register; s_ready drops
// only when both registers are full and the result is not taken
module utf8_to_code_point_decoder
    import utf8d_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_byte_in,
    input  logic [LEFT_W-1:0] s_bytes_left,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CP_W-1:0]   m_cp
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [LEFT_W-1:0] left_reg;
    dec_state_t        state_reg;
    dec_state_t        state_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic [CP_W-1:0]   cp_reg;
    logic              emit;
    logic [CP_W-1:0]   cp_next;
    logic              out_free;
    logic              advance;

    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    utf8d_step u_step (
        .state_cur  (state_reg),
        .byte_in    (byte_reg),
        .bytes_left (left_reg),
        .state_next (state_next),
        .emit       (emit),
        .cp_out     (cp_next)
    );

    always_comb begin
        out_vld_next = out_vld_reg;
        if (out_free) begin
            out_vld_next = advance && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            out_vld_reg <= out_vld_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
            left_reg <= s_bytes_left;
        end
        if (advance && emit) begin
            cp_reg <= cp_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_cp    = cp_reg;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_drop_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.dropping |-> state_reg.pending == '0)
        else $error("drop mode with an open sequence");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(byte_reg) && $stable(left_reg))
        else $error("input register lost a stalled byte");

    a_state_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("decode state moved without a transfer");

endmodule
